[rtl/rxhop_pkg.sv]
// Package for the receive hop scheduler: beat types, register indexes and constants.
`default_nettype none
package rxhop_pkg;

	localparam int TABLE_SIZE = 5;
	localparam int HOP_CHANNELS = 5;

	localparam int TIMER_W = 16;
	localparam int INDEX_W = 3;
	localparam int CHAN_W = 7;
	localparam int SWITCH_W = 4;
	localparam int RETRY_W = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIMER_W-1:0] SLOT_PERIOD_RST = 16'd1000;
	localparam logic [SWITCH_W-1:0] SWITCH_LIMIT = SWITCH_W'(2 * TABLE_SIZE);
	localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(TABLE_SIZE - 1);

	// input commands
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_RECEIVE = 1'b1;

	// retransmit numbers that reload the compare value
	localparam logic [RETRY_W-1:0] RETRY_ZERO = 8'd0;
	localparam logic [RETRY_W-1:0] RETRY_ONE = 8'd1;
	localparam logic [RETRY_W-1:0] RETRY_TWO = 8'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RESYNC_DELAY = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RETRY_STEP = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HOP_CHANNEL_0 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HOP_CHANNEL_1 = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HOP_CHANNEL_2 = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_HOP_CHANNEL_3 = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_HOP_CHANNEL_4 = 3'd7;

	typedef struct packed {
		logic command;
		logic [RETRY_W-1:0] retry_number;
	} item_t;

	typedef struct packed {
		logic slot_expired;
		logic [INDEX_W-1:0] channel_index;
		logic [CHAN_W-1:0] radio_channel;
		logic catching_up;
	} result_t;

endpackage
`default_nettype wire

[rtl/rx_channel_hop_scheduler_unit.sv]
// Receive hop scheduler: slot timer, compare reload, hop index and catch-up control.
//
// Usage:
//   item channel (item_valid / item_stall / item): one beat is a timer tick or a
//   packet-received event with its retransmit number. Scheduler state updates at
//   the edge that accepts the beat.
//   result channel (result_valid / result_stall / result): one beat per item with
//   the expiry flag, hop index, selected radio channel and catch-up flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   always ready; write only while no result is pending.
// The result beat is registered and presented in the cycle after the item is accepted.
// Throughput: one item per cycle unless stalled; the whole update is one pass of a
//   16-bit increment/compare and a two-subtract reload, state to result register.
// Reset: timer, hop index, catch-up state clear; compare value and slot period
//   load 1000; other registers but the result data clear. No result is pending.
// Stall: while a result is held under result_stall, item_stall is raised in the
//   same cycle; the held result does not change.
`default_nettype none
module rx_channel_hop_scheduler_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire rxhop_pkg::item_t                   item,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output rxhop_pkg::result_t                      result,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rxhop_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [rxhop_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration registers
	logic [rxhop_pkg::TIMER_W-1:0] slot_period_q;
	logic [rxhop_pkg::TIMER_W-1:0] resync_delay_q;
	logic [rxhop_pkg::TIMER_W-1:0] retry_step_q;
	logic [rxhop_pkg::CHAN_W-1:0]  hop_channel_q [rxhop_pkg::HOP_CHANNELS];

	// scheduler state
	logic [rxhop_pkg::TIMER_W-1:0]  timer_q;
	logic [rxhop_pkg::TIMER_W-1:0]  compare_q;
	logic [rxhop_pkg::INDEX_W-1:0]  hop_idx_q;
	logic                           catchup_q;
	logic [rxhop_pkg::SWITCH_W-1:0] switch_cnt_q;

	logic result_valid_q;
	rxhop_pkg::result_t result_q;

	logic item_accept;
	logic cfg_write;

	logic [rxhop_pkg::TIMER_W-1:0]  timer_inc;
	logic                           expire_c;
	logic [rxhop_pkg::TIMER_W-1:0]  retry_sub;
	logic [rxhop_pkg::TIMER_W-1:0]  reload_c;
	logic                           reload_en;
	logic [rxhop_pkg::TIMER_W-1:0]  timer_d;
	logic [rxhop_pkg::TIMER_W-1:0]  compare_d;
	logic [rxhop_pkg::INDEX_W-1:0]  hop_idx_d;
	logic                           catchup_d;
	logic [rxhop_pkg::SWITCH_W-1:0] switch_cnt_d;
	logic [rxhop_pkg::INDEX_W-1:0]  chan_sel;
	logic [rxhop_pkg::INDEX_W-1:0]  cfg_chan_idx;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign item_stall = result_valid_q && result_stall;
	assign item_accept = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	assign cfg_chan_idx = cfg_index - rxhop_pkg::REG_HOP_CHANNEL_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_period_q <= rxhop_pkg::SLOT_PERIOD_RST;
			resync_delay_q <= '0;
			retry_step_q <= '0;
			for (int i = 0; i < rxhop_pkg::HOP_CHANNELS; i++)
				hop_channel_q[i] <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index) inside
				rxhop_pkg::REG_SLOT_PERIOD: slot_period_q <= cfg_data;
				rxhop_pkg::REG_RESYNC_DELAY: resync_delay_q <= cfg_data;
				rxhop_pkg::REG_RETRY_STEP: retry_step_q <= cfg_data;
				rxhop_pkg::REG_HOP_CHANNEL_0, rxhop_pkg::REG_HOP_CHANNEL_1,
				rxhop_pkg::REG_HOP_CHANNEL_2, rxhop_pkg::REG_HOP_CHANNEL_3,
				rxhop_pkg::REG_HOP_CHANNEL_4: begin
					hop_channel_q[cfg_chan_idx] <= cfg_data[rxhop_pkg::CHAN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign timer_inc = timer_q + 1'b1;
	assign expire_c = (item.command == rxhop_pkg::CMD_TICK) && (timer_inc >= compare_q);

	always_comb begin
		case (item.retry_number)
			rxhop_pkg::RETRY_ONE: retry_sub = retry_step_q;
			rxhop_pkg::RETRY_TWO: retry_sub = {retry_step_q[rxhop_pkg::TIMER_W-2:0], 1'b0};
			default: retry_sub = '0;
		endcase
	end

	assign reload_c = slot_period_q - resync_delay_q - retry_sub;
	assign reload_en = (item.retry_number == rxhop_pkg::RETRY_ZERO) ||
		(item.retry_number == rxhop_pkg::RETRY_ONE) ||
		(item.retry_number == rxhop_pkg::RETRY_TWO);

	always_comb begin
		timer_d = timer_q;
		compare_d = compare_q;
		hop_idx_d = hop_idx_q;
		catchup_d = catchup_q;
		switch_cnt_d = switch_cnt_q;
		if (item.command == rxhop_pkg::CMD_RECEIVE) begin
			timer_d = '0;
			catchup_d = 1'b1;
			switch_cnt_d = '0;
			if (reload_en)
				compare_d = reload_c;
		end else if (expire_c) begin
			timer_d = '0;
			compare_d = slot_period_q;
			// during catch-up, hop only on even switch counts
			if (!catchup_q || !switch_cnt_q[0]) begin
				if (hop_idx_q >= rxhop_pkg::LAST_INDEX)
					hop_idx_d = '0;
				else
					hop_idx_d = hop_idx_q + 1'b1;
			end
			if (catchup_q) begin
				if (switch_cnt_q >= rxhop_pkg::SWITCH_LIMIT) begin
					catchup_d = 1'b0;
					switch_cnt_d = '0;
				end else begin
					switch_cnt_d = switch_cnt_q + 1'b1;
				end
			end
		end else begin
			timer_d = timer_inc;
		end
	end

	assign chan_sel = (hop_idx_d < rxhop_pkg::INDEX_W'(rxhop_pkg::HOP_CHANNELS)) ? hop_idx_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			compare_q <= rxhop_pkg::SLOT_PERIOD_RST;
			hop_idx_q <= '0;
			catchup_q <= 1'b0;
			switch_cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_accept) begin
				timer_q <= timer_d;
				compare_q <= compare_d;
				hop_idx_q <= hop_idx_d;
				catchup_q <= catchup_d;
				switch_cnt_q <= switch_cnt_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			result_q.slot_expired <= expire_c;
			result_q.channel_index <= hop_idx_d;
			result_q.radio_channel <= hop_channel_q[chan_sel];
			result_q.catching_up <= catchup_d;
		end
	end

	a_receive_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept && item.command == rxhop_pkg::CMD_RECEIVE |=>
			result_valid && result.catching_up && !result.slot_expired)
		else $error("receive beat did not give a catch-up result");

	a_switch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!catchup_q |-> switch_cnt_q == '0)
		else $error("switch count nonzero outside catch-up");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		hop_idx_q <= rxhop_pkg::LAST_INDEX)
		else $error("hop index beyond table");

	a_expire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept && expire_c |=> timer_q == '0 && compare_q == $past(slot_period_q))
		else $error("slot expiry did not restart timer");

endmodule
`default_nettype wire
